### rtl/gpmc_pkg.sv
// gpmc_pkg: shared types, constants and the gf(2^8) multiply for the parity matrix coder
// no dependencies; imported by every module of the coder
`timescale 1ns / 1ps

package gpmc_pkg;

  // field geometry fixed by the beat formats
  localparam int LANE_BITS  = 8;
  localparam int DATA_LANES = 8;
  localparam int ROW_REGS   = 4;
  localparam logic [LANE_BITS-1:0] GF_POLY_LOW = 8'h1D;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_ROW0  = 3'd0,
    REG_COEF_ROW1  = 3'd1,
    REG_COEF_ROW2  = 3'd2,
    REG_COEF_ROW3  = 3'd3,
    REG_DATA_COUNT = 3'd4,
    REG_OUT_COUNT  = 3'd5
  } cfg_reg_e;

  // input beat: one byte column
  typedef struct packed {
    logic [DATA_LANES*LANE_BITS-1:0] data_column;
    logic                            last_column;
  } in_beat_t;

  // result beat: one byte per output row
  typedef struct packed {
    logic [ROW_REGS*LANE_BITS-1:0] parity_column;
    logic                          last_out;
  } out_beat_t;

  // what one cell hands to its neighbor each cycle
  typedef struct packed {
    logic                            valid;
    logic                            last;
    logic [DATA_LANES*LANE_BITS-1:0] column;
    logic [ROW_REGS*LANE_BITS-1:0]   acc;
  } cell_beat_t;

  // shift-and-reduce product with polynomial 0x11d
  function automatic logic [LANE_BITS-1:0] gf_mult(input logic [LANE_BITS-1:0] a,
                                                   input logic [LANE_BITS-1:0] b);
    logic [LANE_BITS-1:0] acc;
    logic [LANE_BITS-1:0] x;
    acc = '0;
    x   = a;
    for (int k = 0; k < LANE_BITS; k++) begin
      if (b[k]) acc = acc ^ x;
      if (x[LANE_BITS-1]) x = {x[LANE_BITS-2:0], 1'b0} ^ GF_POLY_LOW;
      else x = {x[LANE_BITS-2:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

### rtl/gpmc_cell.sv
// gpmc_cell: one data shard stage of the coder chain
// folds the low byte of the column into every row accumulator; uses gpmc_pkg
`timescale 1ns / 1ps

module gpmc_cell import gpmc_pkg::*; (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cell_beat_t                           up_i,
  input  logic [ROW_REGS-1:0][LANE_BITS-1:0]   coef_i,
  input  logic                                 lane_en_i,
  output cell_beat_t                           dn_o
);

  logic                            valid_r;
  logic                            last_r;
  logic [DATA_LANES*LANE_BITS-1:0] column_r;
  logic [ROW_REGS*LANE_BITS-1:0]   acc_r;
  logic [ROW_REGS*LANE_BITS-1:0]   acc_nxt;
  logic [LANE_BITS-1:0]            data_byte;

  // this cell's shard is the low byte of the column it receives
  assign data_byte = up_i.column[LANE_BITS-1:0];

  // accumulate one product per row, skipped for shards not in use
  always_comb begin
    acc_nxt = up_i.acc;
    for (int r = 0; r < ROW_REGS; r++) begin
      if (lane_en_i) begin
        acc_nxt[r*LANE_BITS +: LANE_BITS] = up_i.acc[r*LANE_BITS +: LANE_BITS]
                                            ^ gf_mult(coef_i[r], data_byte);
      end
    end
  end

  // beat valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= up_i.valid;
    end
  end

  // payload, column shifted so the next shard sits low
  always_ff @(posedge clk) begin
    last_r   <= up_i.last;
    column_r <= {{LANE_BITS{1'b0}}, up_i.column[DATA_LANES*LANE_BITS-1:LANE_BITS]};
    acc_r    <= acc_nxt;
  end

  assign dn_o = '{valid: valid_r, last: last_r, column: column_r, acc: acc_r};

endmodule

### rtl/gf256_parity_matrix_coder.sv
// gf256_parity_matrix_coder: top level of the gf(2^8) parity matrix coder
// holds the configuration registers and the chain of gpmc_cell stages; uses gpmc_pkg
`timescale 1ns / 1ps

// One byte column is taken per clock whenever start is high and busy is low
// (busy is high only during reset). Each column runs through a chain of one
// cell per data shard, min(MAX_DATA, 8) cells, so its result appears on
// out_beat with out_valid high for one cycle once it has passed the register
// of every cell; results leave in order at one per cycle. There is no
// flow control on the result side: capture out_beat in the cycle out_valid is
// high. Load coef_row0..3, data_count and out_count only while no column is
// in flight.
module gf256_parity_matrix_coder import gpmc_pkg::*; #(
  parameter int MAX_DATA = 8,
  parameter int MAX_OUT  = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  in_beat_t                        in_beat,
  output logic                            out_valid,
  output out_beat_t                       out_beat,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_idx,
  input  logic [DATA_LANES*LANE_BITS-1:0] cfg_wdata
);

  localparam int NCELL = (MAX_DATA < DATA_LANES) ? MAX_DATA : DATA_LANES;
  localparam int NROW  = (MAX_OUT < ROW_REGS) ? MAX_OUT : ROW_REGS;
  localparam logic [3:0] NCELL_LIM = 4'(NCELL);
  localparam logic [2:0] NROW_LIM  = 3'(NROW);

  logic [ROW_REGS-1:0][DATA_LANES*LANE_BITS-1:0] coef_r;
  logic [3:0]                                    data_count_r;
  logic [2:0]                                    out_count_r;
  logic [3:0]                                    nd;
  logic [2:0]                                    no;
  cell_beat_t                                    chain [NCELL+1];

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r       <= '0;
      data_count_r <= 4'd1;
      out_count_r  <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEF_ROW0:  coef_r[0]    <= cfg_wdata;
        REG_COEF_ROW1:  coef_r[1]    <= cfg_wdata;
        REG_COEF_ROW2:  coef_r[2]    <= cfg_wdata;
        REG_COEF_ROW3:  coef_r[3]    <= cfg_wdata;
        REG_DATA_COUNT: data_count_r <= cfg_wdata[3:0];
        REG_OUT_COUNT:  out_count_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // saturate shard and row counts to what the chain holds
  assign nd = (data_count_r > NCELL_LIM) ? NCELL_LIM : data_count_r;
  assign no = (out_count_r > NROW_LIM) ? NROW_LIM : out_count_r;

  assign busy = !rst_n;

  // feed the head of the chain
  assign chain[0] = '{valid:  start && !busy,
                      last:   in_beat.last_column,
                      column: in_beat.data_column,
                      acc:    '0};

  // one cell per data shard
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [ROW_REGS-1:0][LANE_BITS-1:0] cell_coef;
    for (genvar r = 0; r < ROW_REGS; r++) begin : g_coef
      assign cell_coef[r] = coef_r[r][i*LANE_BITS +: LANE_BITS];
    end
    gpmc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_i      (chain[i]),
      .coef_i    (cell_coef),
      .lane_en_i (4'(i) < nd),
      .dn_o      (chain[i+1])
    );
  end

  // result beat, rows not in use forced to zero
  always_comb begin
    out_beat.last_out = chain[NCELL].last;
    for (int r = 0; r < ROW_REGS; r++) begin
      out_beat.parity_column[r*LANE_BITS +: LANE_BITS] =
        (3'(r) < no) ? chain[NCELL].acc[r*LANE_BITS +: LANE_BITS] : '0;
    end
  end

  assign out_valid = chain[NCELL].valid;

endmodule

### rtl/gpmc_checker.sv
// gpmc_checker: port-level timing checks for the parity matrix coder
// bound to gf256_parity_matrix_coder; uses gpmc_pkg
`timescale 1ns / 1ps

module gpmc_checker import gpmc_pkg::*; #(
  parameter int LAT = 8
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input out_beat_t out_beat
);

  // reset empties the chain
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // every accepted column comes out after the chain latency
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat produced no result");

  // no result without a column taken the chain latency earlier
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without matching input beat");

  // last flag travels with its column
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.last_out == $past(in_beat.last_column, LAT)))
    else $error("last_out does not match its column");

  // an all-zero column gives all-zero parity
  a_zero_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_beat.data_column == '0, LAT)) |-> (out_beat.parity_column == '0))
    else $error("nonzero parity from zero column");

endmodule

bind gf256_parity_matrix_coder gpmc_checker #(.LAT(NCELL)) u_gpmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_beat  (out_beat)
);
